FILE: design/mbgi_pkg.sv
`timescale 1ns / 1ps
package mbgi_pkg;

	localparam int MAX_COLS_DEF    = 256;
	localparam int MAX_ROWS_DEF    = 256;
	localparam int SAMPLE_BITS_DEF = 32;
	localparam int FRAC_BITS_DEF   = 16;

	localparam int POS_W   = 32;
	localparam int INV_W   = 32;
	localparam int CNT_W   = 9;
	localparam int IDX_W   = 8;
	localparam int VALUE_W = 32;
	localparam int CFG_IDX_W  = 3;
	localparam int CFG_DATA_W = 32;

	// result queue depth, covers every query in flight
	localparam int RQ_DEPTH = 16;

	typedef enum logic [CFG_IDX_W-1:0] {
		CFG_ORIGIN_X   = 3'd0,
		CFG_ORIGIN_Y   = 3'd1,
		CFG_INV_CELL_X = 3'd2,
		CFG_INV_CELL_Y = 3'd3,
		CFG_COLS       = 3'd4,
		CFG_ROWS       = 3'd5
	} cfg_reg_t;

	typedef enum logic {
		OP_WRITE = 1'b0,
		OP_QUERY = 1'b1
	} opcode_t;

	typedef struct packed {
		logic               available;
		logic [VALUE_W-1:0] value;
	} result_t;

endpackage

FILE: design/mbgi_locate.sv
`timescale 1ns / 1ps
module mbgi_locate #(
	parameter int MAX_N     = mbgi_pkg::MAX_COLS_DEF,
	parameter int FRAC_BITS = mbgi_pkg::FRAC_BITS_DEF
) (
	input  logic                               clk,
	input  logic signed [mbgi_pkg::POS_W-1:0] pos,
	input  logic signed [mbgi_pkg::POS_W-1:0] origin,
	input  logic        [mbgi_pkg::INV_W-1:0] inv,
	input  logic        [mbgi_pkg::CNT_W-1:0] count,
	output logic        [$clog2(MAX_N)-1:0]    cell_s3,
	output logic        [FRAC_BITS:0]          frac_s3
);
	localparam int CW = $clog2(MAX_N);
	localparam int NW = ($clog2(MAX_N + 1) > mbgi_pkg::CNT_W) ?
		$clog2(MAX_N + 1) : mbgi_pkg::CNT_W;
	localparam int GW = mbgi_pkg::POS_W + mbgi_pkg::INV_W;
	localparam logic [GW-1:0] ONE_Q = GW'(1) << FRAC_BITS;

	logic signed [mbgi_pkg::POS_W:0] d;
	logic [mbgi_pkg::POS_W-1:0] dmag_s1;
	logic le0_s1, le0_s2;
	logic [GW-1:0] g_s2;
	logic [NW-1:0] n_ext, n_clamp, last;
	logic [GW-1:0] gi, r;

	assign d = {pos[mbgi_pkg::POS_W-1], pos} - {origin[mbgi_pkg::POS_W-1], origin};

	always_ff @(posedge clk) begin
		dmag_s1 <= d[mbgi_pkg::POS_W-1:0];
		le0_s1  <= d[mbgi_pkg::POS_W] || (d == '0);
		g_s2    <= GW'(dmag_s1) * GW'(inv);
		le0_s2  <= le0_s1;
	end

	// point count clamped to [2, MAX_N]
	always_comb begin
		n_ext = NW'(count);
		if (n_ext < NW'(2))
			n_clamp = NW'(2);
		else if (n_ext > NW'(MAX_N))
			n_clamp = NW'(MAX_N);
		else
			n_clamp = n_ext;
		last = n_clamp - NW'(2);
		gi   = g_s2 >> FRAC_BITS;
		r    = g_s2 - (GW'(last) << FRAC_BITS);
	end

	always_ff @(posedge clk) begin
		if (le0_s2) begin
			cell_s3 <= '0;
			frac_s3 <= '0;
		end else if (gi >= GW'(last)) begin
			cell_s3 <= last[CW-1:0];
			frac_s3 <= (r > ONE_Q) ? ONE_Q[FRAC_BITS:0] : r[FRAC_BITS:0];
		end else begin
			cell_s3 <= gi[CW-1:0];
			frac_s3 <= {1'b0, g_s2[FRAC_BITS-1:0]};
		end
	end

endmodule

FILE: design/mbgi_bank.sv
`timescale 1ns / 1ps
module mbgi_bank #(
	parameter int DEPTH = 16384,
	parameter int WIDTH = 33
) (
	input  logic                                    clk,
	input  logic                                    we,
	input  logic                                    re,
	input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] addr,
	input  logic [WIDTH-1:0]                        wdata,
	output logic [WIDTH-1:0]                        rdata
);
	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we)
			mem[addr] <= wdata;
		else if (re)
			rdata <= mem[addr];
	end

endmodule

FILE: design/mbgi_blend.sv
`timescale 1ns / 1ps
module mbgi_blend #(
	parameter int SAMPLE_BITS = mbgi_pkg::SAMPLE_BITS_DEF,
	parameter int FRAC_BITS   = mbgi_pkg::FRAC_BITS_DEF
) (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          valid_s4,
	input  logic                          missing_s4,
	input  logic signed [SAMPLE_BITS-1:0] s00,
	input  logic signed [SAMPLE_BITS-1:0] s10,
	input  logic signed [SAMPLE_BITS-1:0] s01,
	input  logic signed [SAMPLE_BITS-1:0] s11,
	input  logic        [FRAC_BITS:0]     fx_s4,
	input  logic        [FRAC_BITS:0]     fy_s4,
	output logic                          valid_s8,
	output mbgi_pkg::result_t             result_s8
);
	localparam int S   = SAMPLE_BITS;
	localparam int PW1 = S + 1 + FRAC_BITS + 2;
	localparam int PW2 = S + 2 + FRAC_BITS + 2;
	localparam logic [PW1-1:0] HALF1 = PW1'(1) << (FRAC_BITS - 1);
	localparam logic [PW2-1:0] HALF2 = PW2'(1) << (FRAC_BITS - 1);

	logic v_s5, v_s6, v_s7;
	logic miss_s5, miss_s6, miss_s7;
	logic signed [PW1-1:0] pt_s5, pb_s5;
	logic signed [S:0] b00_s5, b01_s5, top_s6, bot_s6, top_s7;
	logic [FRAC_BITS:0] fy_s5, fy_s6;
	logic signed [PW2-1:0] p2_s7;

	logic signed [S:0] dt, db, rt, rb;
	logic signed [S+1:0] d2, r2, v;
	logic signed [PW1-1:0] st, sb;
	logic signed [PW2-1:0] s2;
	logic signed [63:0] vx;
	logic [mbgi_pkg::VALUE_W-1:0] vsat;

	always_comb begin
		dt = (S+1)'(s10) - (S+1)'(s00);
		db = (S+1)'(s11) - (S+1)'(s01);
	end

	// x products along the lower and upper rows
	always_ff @(posedge clk) begin
		pt_s5  <= PW1'(dt) * PW1'($signed({1'b0, fx_s4}));
		pb_s5  <= PW1'(db) * PW1'($signed({1'b0, fx_s4}));
		b00_s5 <= (S+1)'(s00);
		b01_s5 <= (S+1)'(s01);
		fy_s5  <= fy_s4;
		miss_s5 <= missing_s4;
	end

	// round half up: floor((p + half) / one)
	always_comb begin
		st = pt_s5 + $signed(HALF1);
		sb = pb_s5 + $signed(HALF1);
		rt = st[FRAC_BITS +: S+1];
		rb = sb[FRAC_BITS +: S+1];
	end

	always_ff @(posedge clk) begin
		top_s6  <= b00_s5 + rt;
		bot_s6  <= b01_s5 + rb;
		fy_s6   <= fy_s5;
		miss_s6 <= miss_s5;
	end

	assign d2 = (S+2)'(bot_s6) - (S+2)'(top_s6);

	always_ff @(posedge clk) begin
		p2_s7   <= PW2'(d2) * PW2'($signed({1'b0, fy_s6}));
		top_s7  <= top_s6;
		miss_s7 <= miss_s6;
	end

	always_comb begin
		s2 = p2_s7 + $signed(HALF2);
		r2 = s2[FRAC_BITS +: S+2];
		v  = (S+2)'(top_s7) + r2;
		vx = 64'(v);
		if (vx > 64'sh7FFF_FFFF)
			vsat = 32'h7FFF_FFFF;
		else if (vx < -64'sh8000_0000)
			vsat = 32'h8000_0000;
		else
			vsat = vx[mbgi_pkg::VALUE_W-1:0];
	end

	always_ff @(posedge clk) begin
		result_s8.available <= !miss_s7;
		result_s8.value     <= miss_s7 ? '0 : vsat;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s5 <= 1'b0;
			v_s6 <= 1'b0;
			v_s7 <= 1'b0;
			valid_s8 <= 1'b0;
		end else begin
			v_s5 <= valid_s4;
			v_s6 <= v_s5;
			v_s7 <= v_s6;
			valid_s8 <= v_s7;
		end
	end

endmodule

FILE: design/mbgi_rqueue.sv
`timescale 1ns / 1ps
module mbgi_rqueue (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              push,
	input  mbgi_pkg::result_t push_data,
	input  logic              pop,
	output logic              not_empty,
	output mbgi_pkg::result_t head
);
	localparam int PW = $clog2(mbgi_pkg::RQ_DEPTH);

	mbgi_pkg::result_t slot_q [mbgi_pkg::RQ_DEPTH];
	logic [PW-1:0] wptr_q, rptr_q;
	logic [PW:0]   count_q;

	assign not_empty = (count_q != '0);
	assign head      = slot_q[rptr_q];

	always_ff @(posedge clk) begin
		if (push)
			slot_q[wptr_q] <= push_data;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wptr_q  <= '0;
			rptr_q  <= '0;
			count_q <= '0;
		end else begin
			if (push)
				wptr_q <= wptr_q + PW'(1);
			if (pop)
				rptr_q <= rptr_q + PW'(1);
			count_q <= count_q + (PW+1)'(push) - (PW+1)'(pop);
		end
	end

endmodule

FILE: design/masked_bilinear_grid_interpolator.sv
`timescale 1ns / 1ps
// Masked bilinear interpolator over a grid of up to MAX_COLS x MAX_ROWS samples, each
// with a missing mark. A write transaction (opcode 0) stores one sample and its mark; a
// query transaction (opcode 1) returns the bilinear blend of the four corners of the
// cell holding (pos_x, pos_y), or available = 0 and value = 0 if any corner is missing.
// The table sits in four single-port banks split by column and row parity, so all four
// corners are read in the same cycle and one transaction is taken every clock unless
// input stall is high. A query's result waits in a sixteen-entry result queue; input stall
// rises while clearing and when sixteen queries are outstanding. After reset a
// clearing pass marks every entry missing, one bank row per cycle, over all
// ceil(MAX_COLS/2)*ceil(MAX_ROWS/2) bank rows (16384 by default), accepting no transaction.
// Configuration registers may be written only while no transaction is in flight.
module masked_bilinear_grid_interpolator #(
	parameter int MAX_COLS    = mbgi_pkg::MAX_COLS_DEF,
	parameter int MAX_ROWS    = mbgi_pkg::MAX_ROWS_DEF,
	parameter int SAMPLE_BITS = mbgi_pkg::SAMPLE_BITS_DEF,
	parameter int FRAC_BITS   = mbgi_pkg::FRAC_BITS_DEF
) (
	input  logic                                  clk,
	input  logic                                  arst_n,
	// configuration port
	input  logic                                  cfg_we,
	input  logic [mbgi_pkg::CFG_IDX_W-1:0]        cfg_index,
	input  logic [mbgi_pkg::CFG_DATA_W-1:0]       cfg_data,
	// input channel
	input  logic                                  in_valid,
	output logic                                  in_stall,
	input  logic                                  opcode,
	input  logic [mbgi_pkg::IDX_W-1:0]            col,
	input  logic [mbgi_pkg::IDX_W-1:0]            row,
	input  logic signed [31:0]                    sample,
	input  logic                                  missing,
	input  logic signed [mbgi_pkg::POS_W-1:0]     pos_x,
	input  logic signed [mbgi_pkg::POS_W-1:0]     pos_y,
	// output channel
	output logic                                  out_valid,
	input  logic                                  out_stall,
	output logic signed [mbgi_pkg::VALUE_W-1:0]   value,
	output logic                                  available
);
	localparam int S        = SAMPLE_BITS;
	localparam int CWX      = $clog2(MAX_COLS);
	localparam int CWY      = $clog2(MAX_ROWS);
	localparam int COLS_H   = (MAX_COLS + 1) / 2;
	localparam int ROWS_H   = (MAX_ROWS + 1) / 2;
	localparam int BANK_D   = COLS_H * ROWS_H;
	localparam int AW       = (BANK_D > 1) ? $clog2(BANK_D) : 1;
	localparam int OW       = $clog2(mbgi_pkg::RQ_DEPTH + 1);

	// configuration registers
	logic signed [mbgi_pkg::POS_W-1:0] origin_x_q, origin_y_q;
	logic [mbgi_pkg::INV_W-1:0] inv_cell_x_q, inv_cell_y_q;
	logic [mbgi_pkg::CNT_W-1:0] cols_q, rows_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			origin_x_q   <= '0;
			origin_y_q   <= '0;
			inv_cell_x_q <= 32'd65536;
			inv_cell_y_q <= 32'd65536;
			cols_q       <= 9'd256;
			rows_q       <= 9'd256;
		end else if (cfg_we) begin
			unique case (cfg_index)
				mbgi_pkg::CFG_ORIGIN_X:   origin_x_q   <= cfg_data;
				mbgi_pkg::CFG_ORIGIN_Y:   origin_y_q   <= cfg_data;
				mbgi_pkg::CFG_INV_CELL_X: inv_cell_x_q <= cfg_data;
				mbgi_pkg::CFG_INV_CELL_Y: inv_cell_y_q <= cfg_data;
				mbgi_pkg::CFG_COLS:       cols_q <= cfg_data[mbgi_pkg::CNT_W-1:0];
				mbgi_pkg::CFG_ROWS:       rows_q <= cfg_data[mbgi_pkg::CNT_W-1:0];
				default: ;
			endcase
		end
	end

	// clearing pass and flow control
	logic clearing_q;
	logic [AW-1:0] clr_addr_q;
	logic [OW-1:0] outstanding_q;
	logic in_acc, out_acc, q_acc;

	assign in_stall = clearing_q || (outstanding_q == OW'(mbgi_pkg::RQ_DEPTH));
	assign in_acc   = in_valid && !in_stall;
	assign q_acc    = in_acc && (opcode == mbgi_pkg::OP_QUERY);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			clearing_q    <= 1'b1;
			clr_addr_q    <= '0;
			outstanding_q <= '0;
		end else begin
			if (clearing_q) begin
				clr_addr_q <= clr_addr_q + AW'(1);
				if (clr_addr_q == AW'(BANK_D - 1))
					clearing_q <= 1'b0;
			end
			outstanding_q <= outstanding_q + OW'(q_acc) - OW'(out_acc);
		end
	end

	// write transaction: bank select and address, carried to stage 3
	logic signed [63:0] sample_ext;
	logic wr_ok;
	logic [1:0] wbank;
	logic [AW-1:0] waddr;
	logic [S:0] wdata;

	always_comb begin
		sample_ext = 64'(sample);
		wr_ok = (32'(col) < 32'(MAX_COLS)) && (32'(row) < 32'(MAX_ROWS));
		wbank = {row[0], col[0]};
		waddr = AW'(32'(row >> 1) * 32'(COLS_H) + 32'(col >> 1));
		wdata = {missing, sample_ext[S-1:0]};
	end

	logic qv_s1, qv_s2, qv_s3, qv_s4;
	logic wv_s1, wv_s2, wv_s3;
	logic [1:0] wbank_s1, wbank_s2, wbank_s3;
	logic [AW-1:0] waddr_s1, waddr_s2, waddr_s3;
	logic [S:0] wdata_s1, wdata_s2, wdata_s3;

	always_ff @(posedge clk) begin
		wbank_s1 <= wbank;
		waddr_s1 <= waddr;
		wdata_s1 <= wdata;
		wbank_s2 <= wbank_s1;
		waddr_s2 <= waddr_s1;
		wdata_s2 <= wdata_s1;
		wbank_s3 <= wbank_s2;
		waddr_s3 <= waddr_s2;
		wdata_s3 <= wdata_s2;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			qv_s1 <= 1'b0;
			qv_s2 <= 1'b0;
			qv_s3 <= 1'b0;
			qv_s4 <= 1'b0;
			wv_s1 <= 1'b0;
			wv_s2 <= 1'b0;
			wv_s3 <= 1'b0;
		end else begin
			qv_s1 <= q_acc;
			qv_s2 <= qv_s1;
			qv_s3 <= qv_s2;
			qv_s4 <= qv_s3;
			wv_s1 <= in_acc && (opcode == mbgi_pkg::OP_WRITE) && wr_ok;
			wv_s2 <= wv_s1;
			wv_s3 <= wv_s2;
		end
	end

	// query: grid coordinate per axis, stages 1 to 3
	logic [CWX-1:0] cx_s3;
	logic [CWY-1:0] cy_s3;
	logic [FRAC_BITS:0] fx_s3, fy_s3, fx_s4, fy_s4;

	mbgi_locate #(.MAX_N(MAX_COLS), .FRAC_BITS(FRAC_BITS)) u_loc_x (
		.clk(clk), .pos(pos_x), .origin(origin_x_q), .inv(inv_cell_x_q),
		.count(cols_q), .cell_s3(cx_s3), .frac_s3(fx_s3)
	);

	mbgi_locate #(.MAX_N(MAX_ROWS), .FRAC_BITS(FRAC_BITS)) u_loc_y (
		.clk(clk), .pos(pos_y), .origin(origin_y_q), .inv(inv_cell_y_q),
		.count(rows_q), .cell_s3(cy_s3), .frac_s3(fy_s3)
	);

	// banks indexed {row parity, column parity}; each corner lands in a different bank
	logic [AW-1:0] bank_addr [4];
	logic [3:0] bank_we, bank_re;
	logic [S:0] bank_wdata [4];
	logic [S:0] bank_rdata [4];
	logic cx0_s4, cy0_s4;

	always_comb begin
		for (int b = 0; b < 4; b++) begin
			logic [31:0] ch, rh;
			ch = 32'(cx_s3 >> 1) + 32'((b[0] == 1'b0) && cx_s3[0]);
			rh = 32'(cy_s3 >> 1) + 32'((b[1] == 1'b0) && cy_s3[0]);
			bank_wdata[b] = clearing_q ? {1'b1, {S{1'b0}}} : wdata_s3;
			bank_we[b] = clearing_q || (wv_s3 && (wbank_s3 == 2'(b)));
			bank_re[b] = qv_s3;
			if (clearing_q)
				bank_addr[b] = clr_addr_q;
			else if (wv_s3)
				bank_addr[b] = waddr_s3;
			else
				bank_addr[b] = AW'(rh * 32'(COLS_H) + ch);
		end
	end

	for (genvar gb = 0; gb < 4; gb++) begin : g_bank
		mbgi_bank #(.DEPTH(BANK_D), .WIDTH(S + 1)) u_bank (
			.clk(clk), .we(bank_we[gb]), .re(bank_re[gb]), .addr(bank_addr[gb]),
			.wdata(bank_wdata[gb]), .rdata(bank_rdata[gb])
		);
	end

	always_ff @(posedge clk) begin
		cx0_s4 <= cx_s3[0];
		cy0_s4 <= cy_s3[0];
		fx_s4  <= fx_s3;
		fy_s4  <= fy_s3;
	end

	// undo the bank swizzle: corner (0,0) sits in bank of the cell's own parity
	logic [S:0] c00, c10, c01, c11;
	logic miss_any;

	always_comb begin
		c00 = bank_rdata[{cy0_s4, cx0_s4}];
		c10 = bank_rdata[{cy0_s4, !cx0_s4}];
		c01 = bank_rdata[{!cy0_s4, cx0_s4}];
		c11 = bank_rdata[{!cy0_s4, !cx0_s4}];
		miss_any = c00[S] || c10[S] || c01[S] || c11[S];
	end

	logic valid_s8;
	mbgi_pkg::result_t result_s8, head;

	mbgi_blend #(.SAMPLE_BITS(S), .FRAC_BITS(FRAC_BITS)) u_blend (
		.clk(clk), .arst_n(arst_n), .valid_s4(qv_s4), .missing_s4(miss_any),
		.s00(c00[S-1:0]), .s10(c10[S-1:0]), .s01(c01[S-1:0]), .s11(c11[S-1:0]),
		.fx_s4(fx_s4), .fy_s4(fy_s4), .valid_s8(valid_s8), .result_s8(result_s8)
	);

	// result queue parts the pipeline from the output stall
	assign out_acc = out_valid && !out_stall;

	mbgi_rqueue u_rq (
		.clk(clk), .arst_n(arst_n), .push(valid_s8), .push_data(result_s8),
		.pop(out_acc), .not_empty(out_valid), .head(head)
	);

	assign value     = head.value;
	assign available = head.available;

endmodule

FILE: test/tb_masked_bilinear_grid_interpolator.sv
`timescale 1ns / 1ps
module tb_masked_bilinear_grid_interpolator;

	localparam int NCOLS = mbgi_pkg::MAX_COLS_DEF;
	localparam int NROWS = mbgi_pkg::MAX_ROWS_DEF;
	localparam int DEPTH = NCOLS * NROWS;
	localparam longint ONE_Q = 64'd1 << mbgi_pkg::FRAC_BITS_DEF;
	// margin for the pipeline to empty after the last result has come back
	localparam int SETTLE_CYCLES = 12;
	// the clearing pass after reset accepts nothing; the limit outlasts it
	localparam int WATCHDOG_LIMIT = 60000;

	logic clk;
	logic arst_n;
	logic cfg_we;
	logic [mbgi_pkg::CFG_IDX_W-1:0] cfg_index;
	logic [mbgi_pkg::CFG_DATA_W-1:0] cfg_data;
	logic in_valid;
	logic in_stall;
	logic opcode;
	logic [mbgi_pkg::IDX_W-1:0] col;
	logic [mbgi_pkg::IDX_W-1:0] row;
	logic signed [31:0] sample;
	logic missing;
	logic signed [mbgi_pkg::POS_W-1:0] pos_x;
	logic signed [mbgi_pkg::POS_W-1:0] pos_y;
	logic out_valid;
	logic out_stall = 1'b0;
	logic signed [mbgi_pkg::VALUE_W-1:0] value;
	logic available;

	masked_bilinear_grid_interpolator dut (
		.clk(clk),
		.arst_n(arst_n),
		.cfg_we(cfg_we),
		.cfg_index(cfg_index),
		.cfg_data(cfg_data),
		.in_valid(in_valid),
		.in_stall(in_stall),
		.opcode(opcode),
		.col(col),
		.row(row),
		.sample(sample),
		.missing(missing),
		.pos_x(pos_x),
		.pos_y(pos_y),
		.out_valid(out_valid),
		.out_stall(out_stall),
		.value(value),
		.available(available)
	);

	// shadow copy of the grid table and its missing marks
	longint grid_samples [DEPTH];
	bit grid_missing [DEPTH];
	bit grid_written [DEPTH];

	// shadow copy of the configuration registers
	longint org_x, org_y;
	longint unsigned inv_x, inv_y;
	int unsigned cols_reg, rows_reg;

	// blends still to come back from the block, oldest first
	mbgi_pkg::result_t pending_blends[$];

	int mismatches = 0;
	int snd_idle_pct;
	int rcv_idle_pct;
	int idle_cycles = 0;
	bit timed_out = 1'b0;

	// clock
	initial begin
		clk = 1'b0;
		forever #10 clk = ~clk;
	end

	// rounded diff * f / ONE, half up
	function automatic longint scale_frac(input longint diff, input longint unsigned f);
		longint hi;
		longint lo;
		if (diff >= 0) begin
			hi = diff / ONE_Q;
		end else begin
			hi = -((-diff + ONE_Q - 1) / ONE_Q);
		end
		lo = diff - hi * ONE_Q;
		return hi * longint'(f)
			+ longint'(((unsigned'(lo) * f) + (ONE_Q >> 1)) >> mbgi_pkg::FRAC_BITS_DEF);
	endfunction

	function automatic longint unsigned clamp_points(input int unsigned n, input int unsigned lim);
		if (n < 2) return 2;
		return (n > lim) ? lim : n;
	endfunction

	// position to cell index and Q16 fraction along one axis
	function automatic void find_cell(input longint pos, input longint org,
			input longint unsigned inv, input longint unsigned n,
			output longint unsigned cidx, output longint unsigned frac);
		longint d;
		longint unsigned g;
		longint unsigned last;
		longint unsigned r;
		d = pos - org;
		last = n - 2;
		if (d <= 0) begin
			cidx = 0;
			frac = 0;
		end else begin
			g = unsigned'(d) * inv;
			if ((g >> mbgi_pkg::FRAC_BITS_DEF) >= last) begin
				r = g - (last << mbgi_pkg::FRAC_BITS_DEF);
				cidx = last;
				frac = (r > ONE_Q) ? ONE_Q : r;
			end else begin
				cidx = g >> mbgi_pkg::FRAC_BITS_DEF;
				frac = g & (ONE_Q - 1);
			end
		end
	endfunction

	function automatic int corner_addr(input logic signed [31:0] px, input logic signed [31:0] py,
			input int k);
		longint unsigned cx, cy, fx, fy;
		find_cell(longint'(px), org_x, inv_x, clamp_points(cols_reg, NCOLS), cx, fx);
		find_cell(longint'(py), org_y, inv_y, clamp_points(rows_reg, NROWS), cy, fy);
		return int'(cy * NCOLS + cx) + ((k & 1) ? 1 : 0) + ((k & 2) ? NCOLS : 0);
	endfunction

	function automatic mbgi_pkg::result_t blend_point(input logic signed [31:0] px,
			input logic signed [31:0] py);
		mbgi_pkg::result_t res;
		longint unsigned cx, cy, fx, fy;
		int a00;
		longint top, bot, v;
		find_cell(longint'(px), org_x, inv_x, clamp_points(cols_reg, NCOLS), cx, fx);
		find_cell(longint'(py), org_y, inv_y, clamp_points(rows_reg, NROWS), cy, fy);
		a00 = int'(cy * NCOLS + cx);
		res.available = 1'b0;
		res.value = '0;
		if (grid_missing[a00] | grid_missing[a00 + 1] | grid_missing[a00 + NCOLS]
				| grid_missing[a00 + NCOLS + 1])
			return res;
		top = grid_samples[a00] + scale_frac(grid_samples[a00 + 1] - grid_samples[a00], fx);
		bot = grid_samples[a00 + NCOLS]
			+ scale_frac(grid_samples[a00 + NCOLS + 1] - grid_samples[a00 + NCOLS], fx);
		v = top + scale_frac(bot - top, fy);
		if (v > 64'sh7FFFFFFF) v = 64'sh7FFFFFFF;
		if (v < -64'sh80000000) v = -64'sh80000000;
		res.available = 1'b1;
		res.value = v[31:0];
		return res;
	endfunction

	// one input transaction, prediction applied at acceptance
	task automatic send_item(input mbgi_pkg::opcode_t op, input logic [7:0] c,
			input logic [7:0] r, input logic signed [31:0] s, input logic m,
			input logic signed [31:0] px, input logic signed [31:0] py);
		int a;
		// each cycle idles with the sender's idle percentage
		while ($urandom_range(0, 99) < snd_idle_pct) begin
			in_valid <= 1'b0;
			@(posedge clk);
		end
		in_valid <= 1'b1;
		opcode <= op;
		col <= c;
		row <= r;
		sample <= s;
		missing <= m;
		pos_x <= px;
		pos_y <= py;
		do @(posedge clk); while (in_stall);
		if (op == mbgi_pkg::OP_WRITE) begin
			a = int'(r) * NCOLS + int'(c);
			grid_samples[a] = longint'(s);
			grid_missing[a] = m;
			grid_written[a] = 1'b1;
		end else begin
			pending_blends.push_back(blend_point(px, py));
		end
	endtask

	task automatic write_entry(input int c, input int r, input logic signed [31:0] s,
			input logic m);
		send_item(mbgi_pkg::OP_WRITE, c[7:0], r[7:0], s, m, $urandom, $urandom);
	endtask

	// corners never written would be read by the block, so fill them first
	task automatic query_point(input logic signed [31:0] px, input logic signed [31:0] py);
		int a;
		for (int k = 0; k < 4; k++) begin
			a = corner_addr(px, py, k);
			if (!grid_written[a])
				write_entry(a % NCOLS, a / NCOLS, $urandom, $urandom_range(0, 4) == 0);
		end
		send_item(mbgi_pkg::OP_QUERY, 8'($urandom), 8'($urandom), $urandom, 1'($urandom),
			px, py);
	endtask

	// wait until every blend is back and the pipe has emptied
	task automatic drain;
		in_valid <= 1'b0;
		while (pending_blends.size() != 0) @(posedge clk);
		repeat (SETTLE_CYCLES) @(posedge clk);
	endtask

	task automatic set_grid(input logic [31:0] ox, input logic [31:0] oy,
			input logic [31:0] ix, input logic [31:0] iy,
			input logic [8:0] nc, input logic [8:0] nr);
		mbgi_pkg::cfg_reg_t idx;
		logic [31:0] d;
		drain();
		for (int k = 0; k < 6; k++) begin
			idx = mbgi_pkg::cfg_reg_t'(k);
			case (idx)
				mbgi_pkg::CFG_ORIGIN_X:   d = ox;
				mbgi_pkg::CFG_ORIGIN_Y:   d = oy;
				mbgi_pkg::CFG_INV_CELL_X: d = ix;
				mbgi_pkg::CFG_INV_CELL_Y: d = iy;
				mbgi_pkg::CFG_COLS:       d = {23'd0, nc};
				default:                  d = {23'd0, nr};
			endcase
			cfg_we <= 1'b1;
			cfg_index <= idx;
			cfg_data <= d;
			@(posedge clk);
		end
		cfg_we <= 1'b0;
		org_x = longint'($signed(ox));
		org_y = longint'($signed(oy));
		inv_x = ix;
		inv_y = iy;
		cols_reg = nc;
		rows_reg = nr;
	endtask

	// point whose grid coordinate lands around the grid, sometimes anywhere
	function automatic logic signed [31:0] pick_pos(input longint org, input longint unsigned inv,
			input int unsigned n);
		longint t;
		longint p;
		if ($urandom_range(0, 9) == 0 || inv == 0) return $urandom;
		t = longint'($urandom_range(0, 32'((clamp_points(n, 256) + 2) * 65536))) - ONE_Q;
		p = org + t / longint'(inv);
		if (p > 64'sh7FFFFFFF) p = 64'sh7FFFFFFF;
		if (p < -64'sh80000000) p = -64'sh80000000;
		return p[31:0];
	endfunction

	function automatic logic [31:0] pick_sample;
		case ($urandom_range(0, 3))
			0: return 32'h7FFFFFFF - $urandom_range(0, 3);
			1: return 32'h80000000 + $urandom_range(0, 3);
			2: return $urandom_range(0, 2000) - 1000;
			default: return $urandom;
		endcase
	endfunction

	task automatic random_grid;
		logic [31:0] ox, oy, ix, iy;
		logic [8:0] nc, nr;
		ox = ($urandom_range(0, 3) == 0) ? $urandom : $urandom_range(0, 2000) - 1000;
		oy = ($urandom_range(0, 3) == 0) ? $urandom : $urandom_range(0, 2000) - 1000;
		case ($urandom_range(0, 5))
			0: begin ix = $urandom; iy = $urandom; end
			1: begin ix = 32'hFFFFFFFF; iy = 1; end
			default: begin ix = $urandom_range(4096, 1 << 20); iy = $urandom_range(4096, 1 << 20); end
		endcase
		case ($urandom_range(0, 7))
			0: begin nc = 256; nr = 256; end
			1: begin nc = 9'($urandom_range(0, 1)); nr = 9'($urandom_range(257, 511)); end
			default: begin nc = 9'($urandom_range(2, 12)); nr = 9'($urandom_range(2, 12)); end
		endcase
		set_grid(ox, oy, ix, iy, nc, nr);
	endtask

	// reset values of the registers, missing and present marks
	task automatic test_reset_state;
		write_entry(0, 0, 32'sd5, 1'b1);
		write_entry(1, 0, 32'sd6, 1'b0);
		write_entry(0, 1, 32'sd7, 1'b0);
		write_entry(1, 1, 32'sd8, 1'b0);
		query_point(32'sd0, 32'sd0);
		write_entry(0, 0, 32'sd5, 1'b0);
		query_point(32'sd1, 32'sd0);
		query_point(32'sd0, -32'sd9);
	endtask

	// extremes of samples and positions, clamping, zero reciprocal, odd counts
	task automatic test_directed;
		set_grid(32'd0, 32'd0, 32'd32768, 32'd32768, 9'd3, 9'd3);
		for (int r = 0; r < 3; r++)
			for (int c = 0; c < 3; c++)
				write_entry(c, r, ((r + c) % 2) ? 32'h80000000 : 32'h7FFFFFFF, 1'b0);
		query_point(32'sd1, 32'sd1);
		query_point(32'sd3, 32'sd1);
		query_point(32'h80000000, 32'h80000000);
		query_point(32'h7FFFFFFF, 32'h7FFFFFFF);
		write_entry(2, 2, 32'sd0, 1'b1);
		query_point(32'sd4, 32'sd4);
		query_point(32'sd1, 32'sd4);
		write_entry(255, 255, 32'h12345678, 1'b0);
		set_grid(32'h7FFFFFFF, 32'h80000000, 32'd0, 32'hFFFFFFFF, 9'd0, 9'd511);
		query_point(32'h80000000, 32'h7FFFFFFF);
		query_point(32'h7FFFFFFF, 32'h80000000);
		set_grid(32'h80000000, 32'h80000000, 32'hFFFFFFFF, 32'd1, 9'd256, 9'd256);
		query_point(32'h7FFFFFFF, 32'h7FFFFFFF);
		query_point(32'h80000001, 32'h7FFFFFFF);
	endtask

	task automatic test_random(input int snd_pct, input int rcv_pct, input int n_items);
		int nc, nr;
		snd_idle_pct = snd_pct;
		rcv_idle_pct = rcv_pct;
		for (int i = 0; i < n_items; i++) begin
			if (i % 100 == 0) random_grid();
			// hold back until everything has come out once per phase
			if (i == n_items / 2) drain();
			nc = int'(clamp_points(cols_reg, NCOLS));
			nr = int'(clamp_points(rows_reg, NROWS));
			if ($urandom_range(0, 9) < 4) begin
				if ($urandom_range(0, 9) == 0)
					write_entry($urandom_range(0, 255), $urandom_range(0, 255), pick_sample(),
						1'($urandom_range(0, 1)));
				else
					write_entry($urandom_range(0, nc - 1), $urandom_range(0, nr - 1),
						pick_sample(), $urandom_range(0, 5) == 0);
			end else begin
				query_point(pick_pos(org_x, inv_x, cols_reg), pick_pos(org_y, inv_y, rows_reg));
			end
		end
	endtask

	// result checking, output stall and watchdog
	always @(posedge clk) begin
		mbgi_pkg::result_t want;
		if ($urandom_range(0, 99) < rcv_idle_pct) out_stall <= 1'b1;
		else out_stall <= 1'b0;
		if ((in_valid && !in_stall) || (out_valid && !out_stall)) idle_cycles <= 0;
		else idle_cycles <= idle_cycles + 1;
		if (idle_cycles >= WATCHDOG_LIMIT) timed_out <= 1'b1;
		if (arst_n && out_valid && !out_stall) begin
			if (pending_blends.size() == 0) begin
				mismatches <= mismatches + 1;
				if (mismatches < 10)
					$display("unexpected transaction: value %0d available %0b", value, available);
			end else begin
				want = pending_blends.pop_front();
				if (want.value !== value || want.available !== available) begin
					mismatches <= mismatches + 1;
					if (mismatches < 10)
						$display("mismatch: expected value %0d available %0b, got %0d %0b",
							$signed(want.value), want.available, value, available);
				end
			end
		end
	end

	always @(posedge clk) begin
		if (timed_out) begin
			$display("TB_ERROR");
			$finish;
		end
	end

	initial begin
		arst_n = 1'b0;
		cfg_we <= 1'b0;
		cfg_index <= '0;
		cfg_data <= '0;
		in_valid <= 1'b0;
		opcode <= 1'b0;
		col <= '0;
		row <= '0;
		sample <= '0;
		missing <= 1'b0;
		pos_x <= '0;
		pos_y <= '0;
		snd_idle_pct = 0;
		rcv_idle_pct = 0;
		org_x = 0;
		org_y = 0;
		inv_x = 65536;
		inv_y = 65536;
		cols_reg = 256;
		rows_reg = 256;
		for (int a = 0; a < DEPTH; a++) begin
			grid_samples[a] = 0;
			grid_missing[a] = 1'b1;
			grid_written[a] = 1'b0;
		end
		repeat (6) @(posedge clk);
		arst_n <= 1'b1;

		test_reset_state();
		test_directed();
		test_random(10, 64, 650);
		test_random(64, 10, 650);
		test_random(0, 0, 650);
		drain();

		if (mismatches == 0 && pending_blends.size() == 0) begin
			$display("TB_OK");
		end else begin
			$display("TB_ERROR");
		end
		$finish;
	end

endmodule

FILE: sim.f
design/mbgi_pkg.sv
design/mbgi_locate.sv
design/mbgi_bank.sv
design/mbgi_blend.sv
design/mbgi_rqueue.sv
design/masked_bilinear_grid_interpolator.sv
test/tb_masked_bilinear_grid_interpolator.sv
